[rtl/poar_pkg.sv]
// ----------------------------------------------------------------------------
// poar_pkg
// Types, register codes and the pitch table for the pulse oscillator with
// linear attack and release.
// ----------------------------------------------------------------------------
package poar_pkg;

  // Fixed widths of the note length and the output sample
  localparam int LENGTH_BITS = 24;
  localparam int SAMPLE_BITS = 16;

  typedef struct packed {
    logic        start_note;
    logic [6:0]  note_number;
    logic [15:0] velocity;
    logic [23:0] note_samples;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          note_active;
    logic                          last_sample;
  } out_item_t;

  // Register indexes
  localparam logic [1:0] REG_DUTY    = 2'd0;
  localparam logic [1:0] REG_RATE    = 2'd1;
  localparam logic [1:0] REG_ATTACK  = 2'd2;
  localparam logic [1:0] REG_RELEASE = 2'd3;

  localparam int unsigned Q15_ONE = 32768;

  // Work codes handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  // Classified item in the queue between front and back
  typedef struct packed {
    op_t         op;
    logic [6:0]  note_number;
    logic [15:0] velocity;
    logic [23:0] note_samples;
  } work_t;

  // Top octave (notes 116..127) in Q16 hertz
  function automatic logic [29:0] top_octave_q16(input logic [3:0] semi);
    logic [29:0] f;
    begin
      case (semi)
        4'd0:    f = 30'd435478539;
        4'd1:    f = 30'd461373440;
        4'd2:    f = 30'd488808132;
        4'd3:    f = 30'd517874176;
        4'd4:    f = 30'd548668578;
        4'd5:    f = 30'd581294109;
        4'd6:    f = 30'd615859655;
        4'd7:    f = 30'd652480576;
        4'd8:    f = 30'd691279090;
        4'd9:    f = 30'd732384684;
        4'd10:   f = 30'd775934544;
        4'd11:   f = 30'd822074013;
        default: f = 30'd0;
      endcase
      return f;
    end
  endfunction

endpackage

[rtl/poar_divider.sv]
// ----------------------------------------------------------------------------
// poar_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module poar_divider #(
  parameter int NUM_BITS = 64,
  parameter int DEN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);
  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q;
  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS-1:0] d;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;

  // Shift in one numerator bit and try a subtract
  always_comb begin
    trial = {rem[DEN_BITS-1:0], q[NUM_BITS-1]};
    diff  = trial - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        d    <= den;
        rem  <= '0;
        cnt  <= CW'(NUM_BITS);
      end else if (busy) begin
        if (!diff[DEN_BITS]) begin
          rem <= diff;
          q   <= {q[NUM_BITS-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NUM_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
endmodule

[rtl/poar_front.sv]
// ----------------------------------------------------------------------------
// poar_front
// Accept items, classify them and queue them for the back end.
// ----------------------------------------------------------------------------
module poar_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  poar_pkg::in_item_t in_item,
  input  logic [17:0]       sample_rate,
  output logic              work_valid,
  input  logic              work_take,
  output poar_pkg::work_t   work
);
  import poar_pkg::*;

  work_t q [2];
  logic  wr_ptr, rd_ptr;
  logic [1:0] count;
  logic  acc;
  work_t cls;

  // Classify: no start is a step; an empty note or zero rate makes a start a plain idle
  always_comb begin
    cls.note_number  = in_item.note_number;
    cls.velocity     = in_item.velocity;
    cls.note_samples = in_item.note_samples;
    if (!in_item.start_note)
      cls.op = OP_STEP;
    else if (in_item.note_samples == '0 || sample_rate == '0)
      cls.op = OP_IDLE;
    else
      cls.op = OP_START;
  end

  assign full       = (count == 2'd2);
  assign acc        = push && !full;
  assign work_valid = (count != 2'd0);
  assign work       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (acc) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (acc) wr_ptr <= ~wr_ptr;
      if (work_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, acc} - {1'b0, work_take};
    end
  end

  assert property (@(posedge clk) disable iff (rst) work_take |-> work_valid)
    else $error("take from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (acc && !work_take) |=> count == $past(count) + 2'd1)
    else $error("count slip");
endmodule

[rtl/poar_back.sv]
// ----------------------------------------------------------------------------
// poar_back
// Note state, phase step and envelope divisions, sample shaping.
// ----------------------------------------------------------------------------
module poar_back #(
  parameter int PHASE_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               work_valid,
  output logic               work_take,
  input  poar_pkg::work_t    work,
  input  logic [6:0]         duty_percent,
  input  logic [17:0]        sample_rate,
  input  logic [23:0]        attack_samples,
  input  logic [23:0]        release_samples,
  output logic               res_valid,
  input  logic               res_take,
  output poar_pkg::out_item_t res
);
  import poar_pkg::*;

  localparam int DN = PHASE_BITS + 16;        // step numerator width
  localparam int DD = 18 + 11;                // step denominator width

  typedef enum logic [2:0] {
    S_WAIT, S_STEPDIV, S_ATK, S_ATKW, S_REL, S_RELW, S_OUT, S_HOLD
  } state_t;

  state_t state;

  logic [PHASE_BITS-1:0]  phase_accumulator, phase_step;
  logic [LENGTH_BITS-1:0] sample_index, note_length, attack_length, release_length;
  logic [15:0]            note_velocity;
  logic                   note_running;
  logic [16:0]            env;

  // Shared divider
  logic          dv_start, dv_done;
  logic [DN-1:0] dv_num, dv_quot;
  logic [DD-1:0] dv_den;

  poar_divider #(.NUM_BITS(DN), .DEN_BITS(DD)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_quot)
  );

  // Step operands; octave and semitone by comparing against multiples of 12
  logic [7:0]  m;
  logic [3:0]  octave, semi;
  logic [DN-1:0] s_num;
  logic [DD-1:0] s_den;
  always_comb begin
    m      = {1'b0, work.note_number} + 8'd4;
    octave = 4'd0;
    for (int j = 1; j <= 10; j++) begin
      if (m >= 8'(12 * j)) octave = 4'(j);
    end
    semi   = 4'(m - {4'd0, octave} * 8'd12);
    s_den  = DD'({11'd0, sample_rate} << (4'd10 - octave));
    s_num  = (DN'(top_octave_q16(semi)) << (PHASE_BITS - 16)) + DN'(s_den >> 1);
  end

  // Envelope operands
  logic [LENGTH_BITS:0] rel_start, k;
  logic atk_on, rel_on;
  always_comb begin
    rel_start = {1'b0, note_length} - {1'b0, release_length};
    k         = {1'b0, sample_index} - rel_start;
    atk_on    = attack_length != '0 && sample_index < attack_length;
    rel_on    = release_length != '0 && {1'b0, sample_index} >= rel_start;
  end

  // Shaping
  logic [PHASE_BITS+6:0] ph100, dutyth;
  logic [6:0]  duty;
  logic        high, last;
  logic [32:0] prod, mag;
  logic [SAMPLE_BITS-1:0] maxpos, outs;
  always_comb begin
    duty   = (duty_percent > 7'd100) ? 7'd100 : duty_percent;
    ph100  = (PHASE_BITS+7)'(phase_accumulator) * (PHASE_BITS+7)'(100);
    dutyth = (PHASE_BITS+7)'(duty) << PHASE_BITS;
    high   = ph100 < dutyth;
    last   = ({1'b0, sample_index} + 1'b1) >= {1'b0, note_length};
    prod   = 33'(note_velocity) * 33'(env);
    mag    = (prod + (33'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
    maxpos = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    if (high) outs = (mag > 33'(maxpos)) ? maxpos : SAMPLE_BITS'(mag);
    else      outs = SAMPLE_BITS'(~mag + 33'd1);
  end

  logic [LENGTH_BITS-1:0] na, nr;
  always_comb begin
    na = (LENGTH_BITS'(attack_samples) > LENGTH_BITS'(work.note_samples))
         ? LENGTH_BITS'(work.note_samples) : LENGTH_BITS'(attack_samples);
    nr = (LENGTH_BITS'(release_samples) > LENGTH_BITS'(work.note_samples))
         ? LENGTH_BITS'(work.note_samples) : LENGTH_BITS'(release_samples);
  end

  assign work_take = (state == S_WAIT) && work_valid;
  assign res_valid = (state == S_HOLD);

  // Sequencer: one item at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_WAIT;
      note_running <= 1'b0;
      dv_start     <= 1'b0;
      phase_accumulator <= '0;
      phase_step   <= '0;
      sample_index <= '0;
      note_length  <= '0;
      attack_length <= '0;
      release_length <= '0;
      note_velocity <= '0;
      env          <= 17'(Q15_ONE);
    end else begin
      dv_start <= 1'b0;
      unique case (state)
        S_WAIT: begin
          if (work_valid) begin
            unique case (work.op)
              OP_IDLE: begin
                note_running <= 1'b0;
                res   <= '0;
                state <= S_HOLD;
              end
              OP_START: begin
                note_length  <= LENGTH_BITS'(work.note_samples);
                note_velocity <= (work.velocity > 16'(Q15_ONE)) ? 16'(Q15_ONE)
                                                                 : work.velocity;
                phase_accumulator <= '0;
                sample_index <= '0;
                attack_length <= na;
                release_length <= nr;
                note_running <= 1'b1;
                dv_num   <= s_num;
                dv_den   <= s_den;
                dv_start <= 1'b1;
                state    <= S_STEPDIV;
              end
              default: begin
                if (note_running) state <= S_ATK;
                else begin
                  res   <= '0;
                  state <= S_HOLD;
                end
              end
            endcase
          end
        end
        S_STEPDIV: if (dv_done) begin
          phase_step <= PHASE_BITS'(dv_quot);
          state <= S_ATK;
        end
        S_ATK: begin
          env <= 17'(Q15_ONE);
          if (atk_on) begin
            dv_num   <= DN'({sample_index, 15'd0});
            dv_den   <= DD'(attack_length);
            dv_start <= 1'b1;
            state    <= S_ATKW;
          end else state <= S_REL;
        end
        S_ATKW: if (dv_done) begin
          env   <= 17'(dv_quot);
          state <= S_REL;
        end
        S_REL: begin
          if (rel_on) begin
            dv_num   <= DN'({release_length - k[LENGTH_BITS-1:0], 15'd0});
            dv_den   <= DD'(release_length);
            dv_start <= 1'b1;
            state    <= S_RELW;
          end else state <= S_OUT;
        end
        S_RELW: if (dv_done) begin
          if (17'(dv_quot) < env) env <= 17'(dv_quot);
          state <= S_OUT;
        end
        S_OUT: begin
          res.sample      <= $signed(outs);
          res.note_active <= 1'b1;
          res.last_sample <= last;
          phase_accumulator <= phase_accumulator + phase_step;
          sample_index <= sample_index + 1'b1;
          if (last) note_running <= 1'b0;
          state <= S_HOLD;
        end
        S_HOLD: if (res_take) state <= S_WAIT;
        default: state <= S_WAIT;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_take |-> res_valid)
    else $error("result taken while none held");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && !res_take) |=> state == S_HOLD)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    work_take |=> state != S_WAIT)
    else $error("work item not started");
endmodule

[rtl/pulse_oscillator_attack_release_top.sv]
// ----------------------------------------------------------------------------
// pulse_oscillator_attack_release_top
// Pulse oscillator with linear attack and release, one item per sample.
// ----------------------------------------------------------------------------
// channel   | handshake          | beat
// input     | push / full        | in_item (start, note, velocity, length)
// result    | pop / empty        | out_item (sample, active, last)
// config    | APB psel..pready   | four registers at 4*i
//
// A beat with both ramps active runs two envelope divisions; each one holds the
// shared bit-serial divider through setup, load, one step per quotient bit and
// finish, and a note start adds a phase step division before them.
// Reset is synchronous. A waiting result holds the back end; the two-entry
// queue keeps input open meanwhile.
// ----------------------------------------------------------------------------
module pulse_oscillator_attack_release_top #(
  parameter int PHASE_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  poar_pkg::in_item_t   in_item,
  output logic                 empty,
  input  logic                 pop,
  output poar_pkg::out_item_t  out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import poar_pkg::*;

  logic [6:0]  duty_percent;
  logic [17:0] sample_rate;
  logic [23:0] attack_samples, release_samples;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_percent    <= 7'd50;
      sample_rate     <= 18'd48000;
      attack_samples  <= '0;
      release_samples <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_DUTY:    duty_percent    <= pwdata[6:0];
        REG_RATE:    sample_rate     <= pwdata[17:0];
        REG_ATTACK:  attack_samples  <= pwdata[23:0];
        REG_RELEASE: release_samples <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DUTY:    prdata = {25'd0, duty_percent};
      REG_RATE:    prdata = {14'd0, sample_rate};
      REG_ATTACK:  prdata = {8'd0, attack_samples};
      REG_RELEASE: prdata = {8'd0, release_samples};
      default:     prdata = '0;
    endcase
  end

  logic  work_valid, work_take, res_valid;
  work_t work;

  poar_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .sample_rate(sample_rate), .work_valid(work_valid), .work_take(work_take),
    .work(work)
  );

  poar_back #(
    .PHASE_BITS(PHASE_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .work_valid(work_valid), .work_take(work_take),
    .work(work), .duty_percent(duty_percent), .sample_rate(sample_rate),
    .attack_samples(attack_samples), .release_samples(release_samples),
    .res_valid(res_valid), .res_take(pop && res_valid), .res(out_item)
  );

  assign empty = !res_valid;
endmodule
